/* src/fsta_pkg.sv */
package fsta_pkg;

    typedef enum logic [2:0] {
        CMD_FILL     = 3'd0,
        CMD_LOCK     = 3'd1,
        CMD_CLEAR    = 3'd2,
        CMD_POLL     = 3'd3,
        CMD_XFER_END = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0,
        ST_FULL  = 2'd1,
        ST_LOCK  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_DONE = 2'd2
    } t_state;

    typedef struct packed {
        logic [2:0] cmd;
        logic [3:0] slot;
        logic       to_response;
        logic       select_high;
        logic       onboard_idle;
    } t_in_item;

    typedef struct packed {
        logic       send_start;
        logic [3:0] send_slot;
        logic       ready_to_send;
        logic       onboard_sent;
        logic       link_busy;
    } t_out_item;

endpackage

/* src/frame_slot_tx_arbiter.sv */
// An accepted item is registered; its result is loaded in the done state once the
// output register is free. A scanning poll first scans, one round-robin step per
// cycle, until a pending slot or the last scanned slot. One item at a time: the
// next item is taken once the result is in the output register.
// Reset (synchronous, active low): all slots empty, scan position 0,
// link busy and ready-to-send set, output register empty.
module frame_slot_tx_arbiter #(
    parameter int CLIENT_SLOTS  = 8,
    parameter int SCANNED_SLOTS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  fsta_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output fsta_pkg::t_out_item o_out
);
    import fsta_pkg::*;

    localparam int PW = (SCANNED_SLOTS > 1) ? $clog2(SCANNED_SLOTS) : 1;
    localparam int CW = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
    localparam int SW = 6;
    localparam logic [SW-1:0] CLIENTS_W = SW'(CLIENT_SLOTS);
    localparam logic [PW-1:0] POS_LAST  = PW'(SCANNED_SLOTS - 1);
    localparam logic [3:0]    OB_CODE   = 4'(CLIENT_SLOTS);
    localparam logic [3:0]    RESP_CODE = 4'(CLIENT_SLOTS + 1);

    t_state    r_state, n_state;
    t_in_item  r_item;
    t_status   r_status [CLIENT_SLOTS];
    logic      r_ob_full;
    logic      r_resp_full;
    logic      r_busy;
    logic      r_ready;
    logic [PW-1:0] r_pos;
    logic [PW-1:0] r_cnt;
    logic      r_hit;
    logic      r_out_valid;
    t_out_item r_out;

    logic          in_acc;
    logic          out_load;
    logic          needs_scan;
    logic [PW-1:0] scan_nxt;
    logic          scan_pend;
    logic          pos_in_range;
    logic          scan_last;
    logic [SW-1:0] item_slot_w;
    logic          item_slot_client;
    t_out_item     res;
    logic          n_busy;
    logic          n_ready;

    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign needs_scan = (i_in.cmd == CMD_POLL) && !r_busy && i_in.select_high
                        && !r_ob_full && !r_resp_full;

    assign scan_nxt     = (r_pos == POS_LAST) ? '0 : r_pos + 1'b1;
    assign scan_pend    = (SW'(scan_nxt) < CLIENTS_W)
                          && (r_status[CW'(scan_nxt)] != ST_EMPTY);
    assign scan_last    = (r_cnt == POS_LAST);
    assign pos_in_range = (SW'(r_pos) < CLIENTS_W);

    assign item_slot_w      = SW'(r_item.slot);
    assign item_slot_client = (item_slot_w < CLIENTS_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = needs_scan ? S_SCAN : S_DONE;
                end
            end
            S_SCAN: begin
                if (scan_pend || scan_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        res     = '0;
        n_busy  = r_busy;
        n_ready = r_ready;
        case (r_item.cmd)
            CMD_CLEAR: begin
                if (item_slot_client) begin
                    n_busy = 1'b0;
                end
            end
            CMD_POLL: begin
                if (!r_busy && r_item.select_high) begin
                    if (r_ob_full) begin
                        res.send_start = 1'b1;
                        res.send_slot  = OB_CODE;
                    end else if (r_resp_full) begin
                        res.send_start = 1'b1;
                        res.send_slot  = RESP_CODE;
                    end else if (r_hit) begin
                        res.send_start = 1'b1;
                        res.send_slot  = 4'(r_pos);
                    end
                    if (res.send_start) begin
                        n_busy  = 1'b1;
                        n_ready = 1'b1;
                    end
                end
            end
            CMD_XFER_END: begin
                res.onboard_sent = r_ob_full;
                n_busy  = 1'b0;
                n_ready = 1'b0;
            end
            default: ;
        endcase
        res.ready_to_send = n_ready;
        res.link_busy     = n_busy;
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_cnt <= '0;
            r_hit <= 1'b0;
        end else if (in_acc) begin
            r_cnt <= '0;
            r_hit <= 1'b0;
        end else if (r_state == S_SCAN) begin
            r_pos <= scan_nxt;
            r_cnt <= r_cnt + 1'b1;
            r_hit <= scan_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CLIENT_SLOTS; i++) begin
                r_status[i] <= ST_EMPTY;
            end
            r_ob_full   <= 1'b0;
            r_resp_full <= 1'b0;
            r_busy      <= 1'b1;
            r_ready     <= 1'b1;
        end else if (out_load) begin
            r_busy  <= n_busy;
            r_ready <= n_ready;
            case (r_item.cmd)
                CMD_FILL: begin
                    if (r_item.to_response) begin
                        r_resp_full <= 1'b1;
                    end else if (item_slot_w == CLIENTS_W) begin
                        r_ob_full <= 1'b1;
                    end else begin
                        for (int i = 0; i < CLIENT_SLOTS; i++) begin
                            if (item_slot_w == SW'(i) && r_status[i] != ST_LOCK) begin
                                r_status[i] <= ST_FULL;
                            end
                        end
                    end
                end
                CMD_LOCK: begin
                    for (int i = 0; i < CLIENT_SLOTS; i++) begin
                        if (item_slot_w == SW'(i)) begin
                            r_status[i] <= ST_LOCK;
                        end
                    end
                end
                CMD_CLEAR: begin
                    for (int i = 0; i < CLIENT_SLOTS; i++) begin
                        if (item_slot_w == SW'(i)) begin
                            r_status[i] <= ST_EMPTY;
                        end
                    end
                end
                CMD_XFER_END: begin
                    if (r_ob_full) begin
                        r_ob_full <= 1'b0;
                    end else if (r_item.onboard_idle) begin
                        if (r_resp_full) begin
                            r_resp_full <= 1'b0;
                        end else if (pos_in_range) begin
                            for (int i = 0; i < CLIENT_SLOTS; i++) begin
                                if (SW'(r_pos) == SW'(i)) begin
                                    r_status[i] <= ST_EMPTY;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LAST)
        else $error("scan position out of range");

    a_idle_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.send_start |-> o_out.send_slot == 4'd0)
        else $error("slot reported without send start");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state != S_IDLE)
        else $error("accepted item did not start work");

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside done state");

endmodule
